// ===== hw/rtl/nmq_pkg.sv =====
// Shared types, codes and default sizes for the named mailbox queue engine.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package nmq_pkg;
	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_OPEN  = 2'd0;
	localparam logic [1:0] MODE_CLOSE = 2'd1;
	localparam logic [1:0] MODE_SEND  = 2'd2;
	localparam logic [1:0] MODE_RECV  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BLOCK      = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_OPEN   = 2'd3;

	// Default sizes.
	localparam int NUM_BOXES_DEF  = 16;
	localparam int BOX_DEPTH_DEF  = 16;
	localparam int NAME_CHARS_DEF = 8;

	// Only ids 0..15 can be addressed by the four-bit id fields.
	localparam int ID_LIMIT = 16;

	// A classified command handed from the front to the back.
	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  box_id;
		logic        in_range;
		logic [63:0] box_name;
		logic [31:0] data_word;
		logic        last;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  box_id_out;
		logic [31:0] data_out;
		logic        box_full;
		logic [7:0]  user_count;
		logic        last_out;
	} res_t;
endpackage

// ===== hw/rtl/nmq_front.sv =====
// Front end: accepts input transactions, masks the name, checks the id range
// and holds the commands in a two-entry queue. Depends on nmq_pkg.
`timescale 1ns / 1ps
module nmq_front #(
	parameter int NUM_BOXES  = nmq_pkg::NUM_BOXES_DEF,
	parameter int NAME_CHARS = nmq_pkg::NAME_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    mode,
	input  logic [3:0]    box_id,
	input  logic [63:0]   box_name,
	input  logic [31:0]   data_word,
	input  logic          last_in_message,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output nmq_pkg::cmd_t cmd
);
	localparam int USABLE = (NUM_BOXES < nmq_pkg::ID_LIMIT) ? NUM_BOXES : nmq_pkg::ID_LIMIT;
	localparam logic [63:0] NameMask = (NAME_CHARS >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * NAME_CHARS)) - 64'd1);

	nmq_pkg::cmd_t ent_q [2];
	nmq_pkg::cmd_t cmd_new;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;

	// Classify the incoming transaction.
	always_comb begin
		cmd_new.mode      = mode;
		cmd_new.box_id    = box_id;
		cmd_new.in_range  = (32'(box_id) < 32'(USABLE));
		cmd_new.box_name  = box_name & NameMask;
		cmd_new.data_word = data_word;
		cmd_new.last      = last_in_message;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && cmd_pop) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

// ===== hw/rtl/nmq_back.sv =====
// Back end: mailbox table, name memory, message memory and the sequencer
// that carries out one command at a time, plus the result register.
// Depends on nmq_pkg.
`timescale 1ns / 1ps
module nmq_back #(
	parameter int NUM_BOXES = nmq_pkg::NUM_BOXES_DEF,
	parameter int BOX_DEPTH = nmq_pkg::BOX_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  nmq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output nmq_pkg::res_t res
);
	localparam int USABLE = (NUM_BOXES < nmq_pkg::ID_LIMIT) ? NUM_BOXES : nmq_pkg::ID_LIMIT;
	localparam int BW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
	localparam int IW = (BW > 4) ? BW : 4;
	localparam int PW = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
	localparam int FW = PW + 1;
	localparam int MW = $clog2(NUM_BOXES * BOX_DEPTH);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISP     = 3'd1;
	localparam logic [2:0] S_SCAN_RD  = 3'd2;
	localparam logic [2:0] S_SCAN_CMP = 3'd3;
	localparam logic [2:0] S_OPEN_FIN = 3'd4;
	localparam logic [2:0] S_RECV     = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	// Per-box control state.
	logic          active_q [NUM_BOXES];
	logic [7:0]    users_q  [NUM_BOXES];
	logic [PW-1:0] head_q   [NUM_BOXES];
	logic [PW-1:0] tail_q   [NUM_BOXES];
	logic [FW-1:0] fill_q   [NUM_BOXES];

	// Memories.
	logic [63:0]   name_mem [NUM_BOXES];
	logic [31:0]   msg_mem  [NUM_BOXES * BOX_DEPTH];
	logic [63:0]   name_rd_q;
	logic [31:0]   msg_rd_q;

	logic [2:0]    state_q;
	nmq_pkg::cmd_t cmd_q;
	nmq_pkg::res_t res_q;
	nmq_pkg::res_t out_q;
	logic          out_valid_q;
	logic [BW-1:0] scan_q;
	logic          match_q;
	logic          free_seen_q;
	logic [BW-1:0] free_idx_q;
	logic [BW-1:0] tgt_q;

	logic [IW-1:0] id_w;
	logic [BW-1:0] cidx;
	logic [MW-1:0] rd_addr;
	logic [MW-1:0] wr_addr;
	logic          msg_we;
	logic          name_we;
	logic          out_load;

	assign id_w     = IW'(cmd_q.box_id);
	assign cidx     = id_w[BW-1:0];
	assign rd_addr  = MW'(MW'(cidx) * MW'(BOX_DEPTH) + MW'(head_q[cidx]));
	assign wr_addr  = MW'(MW'(cidx) * MW'(BOX_DEPTH) + MW'(tail_q[cidx]));
	assign msg_we   = (state_q == S_DISP) && (cmd_q.mode == nmq_pkg::MODE_SEND) &&
		cmd_q.in_range && active_q[cidx] && (fill_q[cidx] != FW'(BOX_DEPTH));
	assign name_we  = (state_q == S_OPEN_FIN) && !match_q && free_seen_q;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Message memory: one write port, registered read at the head of the box.
	always_ff @(posedge clk) begin
		if (msg_we) begin
			msg_mem[wr_addr] <= cmd_q.data_word;
		end
		msg_rd_q <= msg_mem[rd_addr];
	end

	// Name memory: written on allocation, read by the scan.
	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[free_idx_q] <= cmd_q.box_name;
		end
		name_rd_q <= name_mem[scan_q];
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Sequencer and box table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			scan_q      <= '0;
			match_q     <= 1'b0;
			free_seen_q <= 1'b0;
			free_idx_q  <= '0;
			tgt_q       <= '0;
			res_q       <= '0;
			for (int b = 0; b < NUM_BOXES; b++) begin
				active_q[b] <= 1'b0;
				users_q[b]  <= 8'd0;
				head_q[b]   <= '0;
				tail_q[b]   <= '0;
				fill_q[b]   <= '0;
			end
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					res_q.box_id_out <= cmd_q.box_id;
					res_q.data_out   <= 32'd0;
					res_q.last_out   <= cmd_q.last;
					if (cmd_q.mode == nmq_pkg::MODE_OPEN) begin
						res_q.status     <= nmq_pkg::ST_OK;
						res_q.box_full   <= 1'b0;
						res_q.user_count <= 8'd0;
						scan_q           <= '0;
						match_q          <= 1'b0;
						free_seen_q      <= 1'b0;
						state_q          <= S_SCAN_RD;
					end else if (!cmd_q.in_range || !active_q[cidx]) begin
						res_q.status     <= nmq_pkg::ST_NOT_OPEN;
						res_q.box_full   <= 1'b0;
						res_q.user_count <= 8'd0;
						state_q          <= S_DONE;
					end else begin
						case (cmd_q.mode)
							nmq_pkg::MODE_CLOSE: begin
								res_q.status     <= nmq_pkg::ST_OK;
								users_q[cidx]    <= users_q[cidx] - 8'd1;
								res_q.user_count <= users_q[cidx] - 8'd1;
								res_q.box_full   <= (users_q[cidx] != 8'd1) &&
									(fill_q[cidx] == FW'(BOX_DEPTH));
								state_q          <= S_DONE;
								if (users_q[cidx] == 8'd1) begin
									active_q[cidx] <= 1'b0;
									head_q[cidx]   <= '0;
									tail_q[cidx]   <= '0;
									fill_q[cidx]   <= '0;
								end
							end
							nmq_pkg::MODE_SEND: begin
								res_q.user_count <= users_q[cidx];
								state_q          <= S_DONE;
								if (fill_q[cidx] == FW'(BOX_DEPTH)) begin
									res_q.status   <= nmq_pkg::ST_BLOCK;
									res_q.box_full <= 1'b1;
								end else begin
									res_q.status <= nmq_pkg::ST_OK;
									tail_q[cidx] <= (tail_q[cidx] == PW'(BOX_DEPTH - 1)) ?
										'0 : tail_q[cidx] + PW'(1);
									fill_q[cidx]   <= fill_q[cidx] + FW'(1);
									res_q.box_full <= (fill_q[cidx] == FW'(BOX_DEPTH - 1));
								end
							end
							default: begin
								res_q.user_count <= users_q[cidx];
								res_q.box_full   <= (fill_q[cidx] == FW'(BOX_DEPTH));
								if (fill_q[cidx] == '0) begin
									res_q.status <= nmq_pkg::ST_BLOCK;
									state_q      <= S_DONE;
								end else begin
									res_q.status <= nmq_pkg::ST_OK;
									state_q      <= S_RECV;
								end
							end
						endcase
					end
				end
				S_RECV: begin
					// The head word was read while the command was dispatched.
					res_q.data_out <= msg_rd_q;
					res_q.box_full <= 1'b0;
					head_q[cidx]   <= (head_q[cidx] == PW'(BOX_DEPTH - 1)) ?
						'0 : head_q[cidx] + PW'(1);
					fill_q[cidx]   <= fill_q[cidx] - FW'(1);
					state_q        <= S_DONE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					// A live box with the same name wins; else keep the lowest free box.
					if (active_q[scan_q] && (name_rd_q == cmd_q.box_name)) begin
						match_q <= 1'b1;
						tgt_q   <= scan_q;
						state_q <= S_OPEN_FIN;
					end else begin
						if (!active_q[scan_q] && !free_seen_q) begin
							free_seen_q <= 1'b1;
							free_idx_q  <= scan_q;
						end
						if (scan_q == BW'(USABLE - 1)) begin
							state_q <= S_OPEN_FIN;
						end else begin
							scan_q  <= scan_q + BW'(1);
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_OPEN_FIN: begin
					state_q <= S_DONE;
					if (match_q) begin
						if (users_q[tgt_q] != 8'hFF) users_q[tgt_q] <= users_q[tgt_q] + 8'd1;
						res_q.user_count <= (users_q[tgt_q] != 8'hFF) ?
							users_q[tgt_q] + 8'd1 : users_q[tgt_q];
						res_q.box_id_out <= 4'(IW'(tgt_q));
						res_q.box_full   <= (fill_q[tgt_q] == FW'(BOX_DEPTH));
					end else if (free_seen_q) begin
						active_q[free_idx_q] <= 1'b1;
						users_q[free_idx_q]  <= 8'd1;
						head_q[free_idx_q]   <= '0;
						tail_q[free_idx_q]   <= '0;
						fill_q[free_idx_q]   <= '0;
						res_q.user_count     <= 8'd1;
						res_q.box_id_out     <= 4'(IW'(free_idx_q));
					end else begin
						res_q.status <= nmq_pkg::ST_TABLE_FULL;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/named_mailbox_queue_engine_unit.sv =====
// Top level of the named mailbox queue engine: command front end, queue and
// execution back end. Depends on nmq_pkg, nmq_front and nmq_back.
`timescale 1ns / 1ps
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tdata: mode, box_id, box_name, data_word; tlast
//  m_*       out  m_tvalid/m_tready  tdata: status, box_id_out, data_out, box_full,
//                                    user_count; tlast
// Open scans the name memory box by box, reading and then comparing each name;
// receive takes the head word from the registered read of the message memory.
// A two-entry queue keeps the input taking transactions while a command runs.
// Reset clears the box table and control; both memories are not cleared.
// A stalled result holds the back end; the front stalls only when its queue fills.
module named_mailbox_queue_engine_unit #(
	parameter int NUM_BOXES  = nmq_pkg::NUM_BOXES_DEF,
	parameter int BOX_DEPTH  = nmq_pkg::BOX_DEPTH_DEF,
	parameter int NAME_CHARS = nmq_pkg::NAME_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // mode[1:0], box_id[5:2], box_name[69:6], data_word[101:70]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // status, box_id_out, data_out, box_full, user_count
	output logic         m_tlast
);
	nmq_pkg::cmd_t cmd;
	nmq_pkg::res_t res;
	logic          cmd_valid;
	logic          cmd_pop;

	// Command front end with its queue.
	nmq_front #(
		.NUM_BOXES (NUM_BOXES),
		.NAME_CHARS(NAME_CHARS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.mode           (s_tdata[1:0]),
		.box_id         (s_tdata[5:2]),
		.box_name       (s_tdata[69:6]),
		.data_word      (s_tdata[101:70]),
		.last_in_message(s_tlast),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop),
		.cmd            (cmd)
	);

	// Execution back end.
	nmq_back #(
		.NUM_BOXES(NUM_BOXES),
		.BOX_DEPTH(BOX_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	// Pack the result transaction.
	assign m_tdata = {1'b0, res.user_count, res.box_full, res.data_out,
		res.box_id_out, res.status};
	assign m_tlast = res.last_out;
endmodule
